@@ src/gnps_pkg.sv @@
// Shared types, widths and helpers for the grid nearest point search block
`timescale 1ns / 1ps

package gnps_pkg;

    localparam int COORD_W     = 24;
    localparam int ID_W        = 16;
    localparam int TRIG_W      = 16;
    localparam int RAD_W       = 23;
    localparam int CS_W        = 20;
    localparam int DIST_W      = 49;
    localparam int MUL_W       = 25;
    localparam int PROD_W      = 50;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CS_W-1:0] CS_RESET = CS_W'(51);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [PROD_W-1:0] G_MAX = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] G_MIN = -(PROD_W'(8388608));
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(8192);

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_T0,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_DIVX,
        S_DIVY,
        S_DIVR,
        S_BOUND,
        S_CNT_RD,
        S_CNT_WT,
        S_SLOT_RD,
        S_SLOT_WT,
        S_SQX,
        S_SQY,
        S_CMP,
        S_NEXT,
        S_FIN
    } t_state;

    // Q1.14 round to nearest (floor of s + half), add translation, saturate
    function automatic logic signed [COORD_W-1:0] f_round_sat(
        input logic signed [PROD_W-1:0]  s,
        input logic signed [COORD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] g;
        t = s + RND_HALF;
        g = (t >>> 14) + PROD_W'(p);
        if (g > G_MAX) begin
            return G_MAX[COORD_W-1:0];
        end else if (g < G_MIN) begin
            return G_MIN[COORD_W-1:0];
        end
        return g[COORD_W-1:0];
    endfunction

endpackage

@@ src/gnps_div.sv @@
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gnps_div import gnps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [CS_W-1:0]    i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CS_W:0]      r_rem;
    logic [COORD_W-1:0] r_quo;
    logic [CS_W-1:0]    r_dvs;
    logic [CS_W:0]      trial;
    logic               take;

    assign trial = {r_rem[CS_W-1:0], r_quo[COORD_W-1]};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[COORD_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/grid_nearest_point_search_core.sv @@
// Top level: uniform grid point store with nearest point query
//
// channel   dir  handshake                  word
// s_axis    in   i_s_axis_tvalid/o_tready   tdata add/query point, tuser operation
// m_axis    out  o_m_axis_tvalid/i_tready   tdata stored, found, id, distance
// cfg       in   i_cfg_we                   cell size, written when high
//
// Add: two shared divider passes (x, y), then a slot write if the cell has room.
// Query: pose rotation, three divider passes (x, y, radius), then a scan of window
// cells and points (one multiplier for rotation and distance, one slot read port).
// Reset: a clearing pass sweeps all (2*HALF_CELLS+1)^2 cell counts.
// Input is taken only when idle; one result word may wait at the output.
`timescale 1ns / 1ps

module grid_nearest_point_search_core import gnps_pkg::*; #(
    parameter int HALF_CELLS    = 15,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_RADIUS    = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CS_W-1:0]        i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // x_coord, y_coord, point_id, pose_x, pose_y, pose_cos, pose_sin, search_radius
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // stored, found, nearest_id, distance_sq
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int GW    = 2 * HALF_CELLS + 1;
    localparam int CELLS = GW * GW;
    localparam int CIW   = $clog2(GW);
    localparam int CAW   = $clog2(CELLS);
    localparam int KW    = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int NW    = $clog2(CELL_CAPACITY + 1);
    localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int SW    = ((CIW > RW) ? CIW : RW) + 2;
    localparam int SLOTS = CELLS * (2 ** KW);

    localparam logic [CAW-1:0]       GW_C  = CAW'(GW);
    localparam logic [CAW-1:0]       LAST_C = CAW'(CELLS - 1);
    localparam logic signed [SW-1:0] TOP_S = SW'(2 * HALF_CELLS);

    t_state r_state, n_state;

    logic                       r_sub;
    logic                       r_op;
    logic signed [COORD_W-1:0]  r_gx, r_gy, r_px, r_py;
    logic [ID_W-1:0]            r_id;
    logic signed [TRIG_W-1:0]   r_cos, r_sin;
    logic [RAD_W-1:0]           r_rad;
    logic [CS_W-1:0]            r_cs;
    logic signed [PROD_W-1:0]   r_prod, r_acc;
    logic [CIW-1:0]             r_xi, r_yi, r_cx, r_cy, r_xlo, r_xhi, r_yhi;
    logic [RW-1:0]              r_r;
    logic [KW-1:0]              r_k;
    logic [NW-1:0]              r_n;
    logic signed [MUL_W-1:0]    r_dx, r_dy;
    logic                       r_have;
    logic [PROD_W-1:0]          r_best;
    logic [ID_W-1:0]            r_best_id;
    logic                       r_stored;
    logic [CAW-1:0]             r_clr;
    logic                       r_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic [NW-1:0]              r_cnt_q;
    logic [COORD_W*2+ID_W-1:0]  r_slot_q;

    logic [NW-1:0]              cnt_mem [CELLS];
    logic [COORD_W*2+ID_W-1:0]  slot_mem [SLOTS];

    logic                       s_acc;
    logic                       div_start, div_done;
    logic [COORD_W-1:0]         div_dividend, div_quo;
    logic [CS_W-1:0]            div_divisor;
    logic                       div_neg, q_ok;
    logic [CIW-1:0]             idx;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic                       cnt_we, slot_we, out_load;
    logic [NW-1:0]              cnt_wdata;
    logic [CAW-1:0]             cell_addr, cnt_waddr;
    logic [PROD_W-1:0]          dist_sum;
    logic                       last_pt;
    logic signed [SW-1:0]       sx, sy, sr, xlo_s, xhi_s, ylo_s, yhi_s;
    logic [CIW-1:0]             xlo, xhi, ylo, yhi;

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign div_divisor = (r_cs == '0) ? CS_W'(1) : r_cs;
    assign q_ok        = div_quo <= COORD_W'(HALF_CELLS);
    assign div_neg     = (r_state == S_DIVX) ? r_gx[COORD_W-1] : r_gy[COORD_W-1];
    assign idx         = div_neg ? (CIW'(HALF_CELLS) - CIW'(div_quo))
                                 : (CIW'(HALF_CELLS) + CIW'(div_quo));

    assign mul_p     = mul_a * mul_b;
    assign cell_addr = CAW'(CAW'(r_cy) * GW_C + CAW'(r_cx));
    assign cnt_waddr = (r_state == S_CLR) ? r_clr : cell_addr;
    assign dist_sum  = PROD_W'(r_acc + r_prod);
    assign last_pt   = (NW'(r_k) + NW'(1)) == r_n;

    assign sx    = SW'(r_xi);
    assign sy    = SW'(r_yi);
    assign sr    = SW'(r_r);
    assign xlo_s = sx - sr;
    assign xhi_s = sx + sr;
    assign ylo_s = sy - sr;
    assign yhi_s = sy + sr;
    assign xlo   = (xlo_s < 0) ? '0 : CIW'(xlo_s);
    assign ylo   = (ylo_s < 0) ? '0 : CIW'(ylo_s);
    assign xhi   = (xhi_s > TOP_S) ? CIW'(TOP_S) : CIW'(xhi_s);
    assign yhi   = (yhi_s > TOP_S) ? CIW'(TOP_S) : CIW'(yhi_s);

    gnps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = '0;
        mul_a        = '0;
        mul_b        = '0;
        cnt_we       = 1'b0;
        slot_we      = 1'b0;
        cnt_wdata    = '0;
        out_load     = 1'b0;
        unique case (r_state)
            S_CLR: begin
                cnt_we = 1'b1;
                if (r_clr == LAST_C) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (i_s_axis_tuser == OP_QUERY) ? S_T0 : S_DIVX;
                end
            end
            S_T0: begin
                mul_a   = MUL_W'(r_cos);
                mul_b   = MUL_W'(r_gx);
                n_state = S_T1;
            end
            S_T1: begin
                mul_a   = MUL_W'(r_sin);
                mul_b   = MUL_W'(r_gy);
                n_state = S_T2;
            end
            S_T2: begin
                mul_a   = MUL_W'(r_sin);
                mul_b   = MUL_W'(r_gx);
                n_state = S_T3;
            end
            S_T3: begin
                mul_a   = MUL_W'(r_cos);
                mul_b   = MUL_W'(r_gy);
                n_state = S_T4;
            end
            S_T4: begin
                n_state = S_DIVX;
            end
            S_DIVX: begin
                div_dividend = r_gx[COORD_W-1] ? COORD_W'(-r_gx) : COORD_W'(r_gx);
                div_start    = !r_sub;
                if (r_sub && div_done) begin
                    n_state = q_ok ? S_DIVY : S_FIN;
                end
            end
            S_DIVY: begin
                div_dividend = r_gy[COORD_W-1] ? COORD_W'(-r_gy) : COORD_W'(r_gy);
                div_start    = !r_sub;
                if (r_sub && div_done) begin
                    if (!q_ok) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = (r_op == OP_QUERY) ? S_DIVR : S_CNT_RD;
                    end
                end
            end
            S_DIVR: begin
                div_dividend = COORD_W'(r_rad);
                div_start    = !r_sub;
                if (r_sub && div_done) begin
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                n_state = S_CNT_WT;
            end
            S_CNT_WT: begin
                if (r_op == OP_ADD) begin
                    if (r_cnt_q < NW'(CELL_CAPACITY)) begin
                        cnt_we    = 1'b1;
                        slot_we   = 1'b1;
                        cnt_wdata = r_cnt_q + NW'(1);
                    end
                    n_state = S_FIN;
                end else begin
                    n_state = (r_cnt_q == '0) ? S_NEXT : S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                n_state = S_SLOT_WT;
            end
            S_SLOT_WT: begin
                n_state = S_SQX;
            end
            S_SQX: begin
                mul_a   = r_dx;
                mul_b   = r_dx;
                n_state = S_SQY;
            end
            S_SQY: begin
                mul_a   = r_dy;
                mul_b   = r_dy;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = last_pt ? S_NEXT : S_SLOT_RD;
            end
            S_NEXT: begin
                n_state = (r_cx == r_xhi && r_cy == r_yhi) ? S_FIN : S_CNT_RD;
            end
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_sub       <= 1'b0;
            r_cs        <= CS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cs <= i_cfg_wdata;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + CAW'(1);
            end
            if (div_start) begin
                r_sub <= 1'b1;
            end else if (div_done) begin
                r_sub <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_op      <= i_s_axis_tuser;
                    r_gx      <= i_s_axis_tdata[23:0];
                    r_gy      <= i_s_axis_tdata[47:24];
                    r_id      <= i_s_axis_tdata[63:48];
                    r_px      <= i_s_axis_tdata[87:64];
                    r_py      <= i_s_axis_tdata[111:88];
                    r_cos     <= i_s_axis_tdata[127:112];
                    r_sin     <= i_s_axis_tdata[143:128];
                    r_rad     <= i_s_axis_tdata[166:144];
                    r_have    <= 1'b0;
                    r_best    <= '0;
                    r_best_id <= '0;
                    r_stored  <= 1'b0;
                end
            end
            S_T1: r_acc <= r_prod;
            S_T2: r_gx  <= f_round_sat(r_acc - r_prod, r_px);
            S_T3: r_acc <= r_prod;
            S_T4: r_gy  <= f_round_sat(r_acc + r_prod, r_py);
            S_DIVX: begin
                if (r_sub && div_done) begin
                    r_xi <= idx;
                    r_cx <= idx;
                end
            end
            S_DIVY: begin
                if (r_sub && div_done) begin
                    r_yi <= idx;
                    r_cy <= idx;
                end
            end
            S_DIVR: begin
                if (r_sub && div_done) begin
                    r_r <= (div_quo > COORD_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(div_quo);
                end
            end
            S_BOUND: begin
                r_cx  <= xlo;
                r_xlo <= xlo;
                r_xhi <= xhi;
                r_cy  <= ylo;
                r_yhi <= yhi;
            end
            S_CNT_WT: begin
                r_n <= r_cnt_q;
                r_k <= '0;
                if (slot_we) begin
                    r_stored <= 1'b1;
                end
            end
            S_SLOT_WT: begin
                r_dx <= MUL_W'($signed(r_slot_q[COORD_W-1:0])) - MUL_W'(r_gx);
                r_dy <= MUL_W'($signed(r_slot_q[2*COORD_W-1:COORD_W])) - MUL_W'(r_gy);
            end
            S_SQY: r_acc <= r_prod;
            S_CMP: begin
                r_k <= r_k + KW'(1);
                if (!r_have || dist_sum < r_best) begin
                    r_have    <= 1'b1;
                    r_best    <= dist_sum;
                    r_best_id <= r_slot_q[2*COORD_W+ID_W-1:2*COORD_W];
                end
            end
            S_NEXT: begin
                if (r_cx == r_xhi) begin
                    r_cx <= r_xlo;
                    r_cy <= r_cy + CIW'(1);
                end else begin
                    r_cx <= r_cx + CIW'(1);
                end
            end
            S_FIN: begin
                if (out_load) begin
                    r_out_data <= {(OUT_TDATA_W - DIST_W - ID_W - 2)'(0),
                                   r_best[DIST_W-1:0], r_best_id, r_have, r_stored};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[cell_addr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[{cell_addr, r_cnt_q[KW-1:0]}] <= {r_id, r_gy, r_gx};
        end
        r_slot_q <= slot_mem[{cell_addr, r_k}];
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot_we |-> r_cnt_q < NW'(CELL_CAPACITY)))
        else $error("slot write into a full cell");

    a_scan_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_RD |-> (r_cx <= CIW'(TOP_S) && r_cy <= CIW'(TOP_S))))
        else $error("cell index outside grid");

    a_slot_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT_RD |-> NW'(r_k) < r_n))
        else $error("slot read beyond cell count");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load |=> !(o_m_axis_tdata[0] && o_m_axis_tdata[1])))
        else $error("result both stored and found");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_start |=> r_state != S_IDLE))
        else $error("divider started outside a divide step");

endmodule
